@@ src/tlrb_pkg.sv @@
// Shared constants, capture struct and byte codes for the text line record blocker.
package tlrb_pkg;

	localparam int BLOCK_BYTES = 768;
	localparam int LINE_LIMIT  = 254;
	localparam int PIECE_BYTES = 32;
	localparam int PIECES      = (BLOCK_BYTES + PIECE_BYTES - 1) / PIECE_BYTES;
	localparam int EMIT_SPAN   = PIECES * PIECE_BYTES;
	localparam int MAX_REC     = BLOCK_BYTES - 10;
	localparam int BA_W        = $clog2(BLOCK_BYTES);
	localparam int EI_W        = $clog2(EMIT_SPAN) + 1;
	localparam int PB_W        = $clog2(PIECE_BYTES);
	localparam int LA_W        = 8;
	localparam int LINE_DEPTH  = 256;
	localparam int WO_W        = 16;
	localparam int FA_W        = WO_W + 1;
	localparam int PIECE_W     = PIECE_BYTES * 8;

	localparam logic [7:0] CH_LF      = 8'h0A;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_SP      = 8'h20;
	localparam logic [7:0] HDR_FRESH  = 8'h60;
	localparam logic [7:0] HDR_FIRST  = 8'h40;
	localparam logic [7:0] TRL_MARK   = 8'h20;
	localparam logic [7:0] EOF_HDR    = 8'h80;
	localparam logic [7:0] EOF_TRL    = 8'hA0;
	localparam logic [7:0] OFS_RESET  = 8'h04;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic       piece_end;
		logic       eob;
		logic       eof;
		logic       last;
	} cap_t;

endpackage

@@ src/tlrb_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module tlrb_ram #(
	parameter int DEPTH = 256,
	parameter int AW    = 8,
	parameter int DW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

endmodule

@@ src/tlrb_drain.sv @@
// Piece assembly from block read-out bytes and the output register slot.
module tlrb_drain
	import tlrb_pkg::*;
(
	input  logic           clk,
	input  logic           arst_n,
	input  cap_t           cap,
	output logic           full,
	output logic           m_axis_tvalid,
	input  logic           m_axis_tready,
	output logic [255:0]   m_axis_tdata,
	output logic [1:0]     m_axis_tuser,
	output logic           m_axis_tlast
);

	logic [PIECE_W-1:0] piece_q;
	logic               full_q;
	logic               eob_q;
	logic               eof_q;
	logic               last_q;
	logic               out_v_q;
	logic [255:0]       out_data_q;
	logic [1:0]         out_user_q;
	logic               out_last_q;
	logic               move;

	assign move = full_q && (!out_v_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (move) begin
				full_q  <= 1'b0;
				out_v_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end
			if (cap.valid && cap.piece_end) begin
				full_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cap.valid) begin
			piece_q <= {piece_q[PIECE_W-9:0], cap.data};
			if (cap.piece_end) begin
				eob_q  <= cap.eob;
				eof_q  <= cap.eof;
				last_q <= cap.last;
			end
		end
		if (move) begin
			// first byte of the piece sits in the top bits; word 0 goes lowest
			out_data_q <= {piece_q[63:0], piece_q[127:64], piece_q[191:128], piece_q[255:192]};
			out_user_q <= {eof_q, eob_q};
			out_last_q <= last_q && eob_q;
		end
	end

	assign full          = full_q;
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;
	assign m_axis_tlast  = out_last_q;

endmodule

@@ src/text_line_record_blocker.sv @@
// Top level: line buffer, record placement into the block memory, block drain.
//
//  channel  dir  tdata                         tuser                   tlast
//  s_axis   in   [7:0] text_byte               [0] cmd                 -
//  m_axis   out  [255:0] block_word_0..3       [0] end_of_block        last
//                (word 0 in bits 63:0)         [1] end_of_file
//
// A text byte is accepted in S_IDLE and written to the line memory in S_STC; one that
// follows a held CR waits while S_STCR writes the CR first. Closing a line copies it
// into the block memory at one byte a cycle. Draining a block reads the block memory
// one byte a cycle while the output slot is free, pausing as each 32-byte piece is
// handed to the output register and while the output is stalled.
// After reset a clearing pass writes all 768 bytes of the empty block; no transfer is
// taken during it. The block memory's single write port paces all of this.
module text_line_record_blocker
	import tlrb_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [7:0]   s_axis_tdata,   // [7:0] text_byte
	input  logic         s_axis_tuser,   // [0] cmd
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [255:0] m_axis_tdata,   // [63:0] word 0 .. [255:192] word 3
	output logic [1:0]   m_axis_tuser,   // [0] end_of_block, [1] end_of_file
	output logic         m_axis_tlast
);

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_STCR, S_STC, S_FIN, S_HDR0, S_HDR2, S_HDR3, S_COPY,
		S_TRL0, S_TRL1, S_OFSH, S_OFSL, S_EOF, S_E0, S_E2, S_E3, S_E4, S_EMIT, S_DONE
	} state_t;

	state_t            state_q;
	state_t            ret_q;
	logic [LA_W-1:0]   line_cnt_q;
	logic              pend_cr_q;
	logic [WO_W-1:0]   wo_q;
	logic [7:0]        c_q;
	logic              lf_q;
	logic              resume_q;
	logic [7:0]        cnt_q;
	logic              blank_q;
	logic              eof_mode_q;
	logic              emit_last_q;
	logic [7:0]        cp_idx_q;
	logic              cp_v_s1;
	logic [FA_W-1:0]   cp_addr_s1;
	logic [EI_W-1:0]   em_idx_q;
	logic              em_v_s1;
	logic              em_inb_s1;
	logic [EI_W-1:0]   em_idx_s1;

	logic              in_xfer;
	logic              full;
	logic              em_inb;
	logic              em_issue;
	logic              s1_piece_end;
	logic              bw_en;
	logic [FA_W-1:0]   bw_addr;
	logic [7:0]        bw_data;
	logic              bw_we;
	logic [7:0]        blk_rd;
	logic [7:0]        line_rd;
	logic              line_we;
	logic [7:0]        line_wdata;
	logic [7:0]        cnt_n;
	logic              fit_fail;
	logic              eof_fit_fail;
	logic [7:0]        hdr0;
	logic              lim_hit;
	cap_t              cap;

	function automatic logic [7:0] clr_val(input logic [BA_W-1:0] a, input logic rst_pat);
		if (a == BA_W'(4)) begin
			return HDR_FRESH;
		end else if (rst_pat && a == BA_W'(3)) begin
			return OFS_RESET;
		end
		return 8'h00;
	endfunction

	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);

	assign em_inb       = em_idx_q < EI_W'(BLOCK_BYTES);
	assign s1_piece_end = em_idx_s1[PB_W-1:0] == PB_W'(PIECE_BYTES - 1);
	// hold issue while a finished piece waits or is about to land
	assign em_issue     = (state_q == S_EMIT) && (em_idx_q < EI_W'(EMIT_SPAN)) && !full
	                      && !(em_v_s1 && s1_piece_end);

	assign hdr0    = (wo_q == WO_W'(4)) ? HDR_FIRST : 8'h00;
	assign lim_hit = ({1'b0, line_cnt_q} + 9'd1) == 9'(LINE_LIMIT - 1);

	always_comb begin
		logic [7:0] raw;
		raw = (lf_q && line_cnt_q == '0) ? 8'd1 : line_cnt_q;
		if (16'(raw) > 16'(MAX_REC)) begin
			cnt_n = 8'(MAX_REC);
		end else begin
			cnt_n = raw;
		end
	end

	assign fit_fail     = ({1'b0, wo_q} + FA_W'(cnt_n) + FA_W'(6)) >= FA_W'(BLOCK_BYTES);
	assign eof_fit_fail = ({1'b0, wo_q} + FA_W'(6)) >= FA_W'(BLOCK_BYTES);

	always_comb begin
		line_we    = 1'b0;
		line_wdata = c_q;
		if (state_q == S_STCR) begin
			line_we    = 1'b1;
			line_wdata = CH_CR;
		end else if (state_q == S_STC) begin
			line_we = 1'b1;
		end
	end

	always_comb begin
		bw_en   = 1'b0;
		bw_addr = '0;
		bw_data = 8'h00;
		case (state_q)
			S_CLEAR: begin
				bw_en   = 1'b1;
				bw_addr = FA_W'(em_idx_q);
				bw_data = clr_val(em_idx_q[BA_W-1:0], 1'b1);
			end
			S_EMIT: begin
				bw_en   = em_issue && em_inb;
				bw_addr = FA_W'(em_idx_q);
				bw_data = clr_val(em_idx_q[BA_W-1:0], eof_mode_q);
			end
			S_HDR0, S_E0: begin
				bw_en   = 1'b1;
				bw_addr = {1'b0, wo_q};
				bw_data = hdr0;
			end
			S_HDR2: begin
				bw_en   = 1'b1;
				bw_addr = {1'b0, wo_q} + FA_W'(2);
			end
			S_HDR3: begin
				bw_en   = 1'b1;
				bw_addr = {1'b0, wo_q} + FA_W'(3);
				bw_data = cnt_q;
			end
			S_COPY: begin
				bw_en   = cp_v_s1;
				bw_addr = cp_addr_s1;
				bw_data = blank_q ? CH_SP : line_rd;
			end
			S_TRL0: begin
				bw_en   = 1'b1;
				bw_addr = {1'b0, wo_q} + FA_W'(cnt_q) + FA_W'(4);
				bw_data = TRL_MARK;
			end
			S_TRL1: begin
				bw_en   = 1'b1;
				bw_addr = {1'b0, wo_q} + FA_W'(cnt_q) + FA_W'(5);
				bw_data = cnt_q;
			end
			S_OFSH: begin
				bw_en   = 1'b1;
				bw_addr = FA_W'(2);
				bw_data = wo_q[15:8];
			end
			S_OFSL: begin
				bw_en   = 1'b1;
				bw_addr = FA_W'(3);
				bw_data = wo_q[7:0];
			end
			S_E2: begin
				bw_en   = 1'b1;
				bw_addr = {1'b0, wo_q} + FA_W'(2);
				bw_data = EOF_HDR;
			end
			S_E3: begin
				bw_en   = 1'b1;
				bw_addr = {1'b0, wo_q} + FA_W'(3);
			end
			S_E4: begin
				bw_en   = 1'b1;
				bw_addr = {1'b0, wo_q} + FA_W'(4);
				bw_data = EOF_TRL;
			end
			default: begin
				bw_en = 1'b0;
			end
		endcase
	end

	assign bw_we = bw_en && (bw_addr < FA_W'(BLOCK_BYTES));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			ret_q       <= S_IDLE;
			line_cnt_q  <= '0;
			pend_cr_q   <= 1'b0;
			wo_q        <= WO_W'(4);
			lf_q        <= 1'b0;
			resume_q    <= 1'b0;
			blank_q     <= 1'b0;
			eof_mode_q  <= 1'b0;
			emit_last_q <= 1'b0;
			cp_idx_q    <= '0;
			cp_v_s1     <= 1'b0;
			em_idx_q    <= '0;
			em_v_s1     <= 1'b0;
		end else begin
			em_v_s1 <= em_issue;
			case (state_q)
				S_CLEAR: begin
					if (em_idx_q == EI_W'(BLOCK_BYTES - 1)) begin
						em_idx_q <= '0;
						state_q  <= S_IDLE;
					end else begin
						em_idx_q <= em_idx_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (in_xfer) begin
						if (s_axis_tuser) begin
							state_q <= S_EOF;
						end else if (pend_cr_q) begin
							pend_cr_q <= 1'b0;
							if (s_axis_tdata == CH_LF) begin
								lf_q     <= 1'b1;
								resume_q <= 1'b0;
								state_q  <= S_FIN;
							end else begin
								state_q <= S_STCR;
							end
						end else if (s_axis_tdata == CH_LF) begin
							lf_q     <= 1'b1;
							resume_q <= 1'b0;
							state_q  <= S_FIN;
						end else if (s_axis_tdata == CH_CR) begin
							pend_cr_q <= 1'b1;
						end else begin
							state_q <= S_STC;
						end
					end
				end
				S_STCR: begin
					line_cnt_q <= line_cnt_q + 1'b1;
					if (lim_hit) begin
						lf_q     <= 1'b0;
						resume_q <= 1'b1;
						state_q  <= S_FIN;
					end else if (c_q == CH_CR) begin
						pend_cr_q <= 1'b1;
						state_q   <= S_IDLE;
					end else begin
						state_q <= S_STC;
					end
				end
				S_STC: begin
					line_cnt_q <= line_cnt_q + 1'b1;
					if (lim_hit) begin
						lf_q     <= 1'b0;
						resume_q <= 1'b0;
						state_q  <= S_FIN;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_FIN: begin
					blank_q  <= lf_q && (line_cnt_q == '0);
					cp_idx_q <= '0;
					if (fit_fail) begin
						wo_q        <= WO_W'(4);
						eof_mode_q  <= 1'b0;
						emit_last_q <= 1'b1;
						ret_q       <= S_HDR0;
						state_q     <= S_EMIT;
					end else begin
						state_q <= S_HDR0;
					end
				end
				S_HDR0: state_q <= S_HDR2;
				S_HDR2: state_q <= S_HDR3;
				S_HDR3: state_q <= S_COPY;
				S_COPY: begin
					if (cp_idx_q < cnt_q) begin
						cp_v_s1  <= 1'b1;
						cp_idx_q <= cp_idx_q + 1'b1;
					end else begin
						cp_v_s1 <= 1'b0;
						if (!cp_v_s1) begin
							state_q <= S_TRL0;
						end
					end
				end
				S_TRL0: state_q <= S_TRL1;
				S_TRL1: begin
					wo_q    <= WO_W'({1'b0, wo_q} + FA_W'(cnt_q) + FA_W'(4));
					state_q <= S_OFSH;
				end
				S_OFSH: state_q <= S_OFSL;
				S_OFSL: begin
					if (eof_mode_q) begin
						emit_last_q <= 1'b1;
						ret_q       <= S_DONE;
						state_q     <= S_EMIT;
					end else begin
						line_cnt_q <= '0;
						if (resume_q && c_q == CH_CR) begin
							pend_cr_q <= 1'b1;
							state_q   <= S_IDLE;
						end else if (resume_q) begin
							state_q <= S_STC;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_EOF: begin
					eof_mode_q <= 1'b0;
					if (eof_fit_fail) begin
						wo_q        <= WO_W'(4);
						emit_last_q <= 1'b0;
						ret_q       <= S_E0;
						state_q     <= S_EMIT;
					end else begin
						state_q <= S_E0;
					end
				end
				S_E0: state_q <= S_E2;
				S_E2: state_q <= S_E3;
				S_E3: state_q <= S_E4;
				S_E4: begin
					wo_q       <= WO_W'({1'b0, wo_q} + FA_W'(4));
					eof_mode_q <= 1'b1;
					state_q    <= S_OFSH;
				end
				S_EMIT: begin
					if (em_issue) begin
						em_idx_q <= em_idx_q + 1'b1;
					end else if (em_idx_q == EI_W'(EMIT_SPAN) && !em_v_s1) begin
						em_idx_q <= '0;
						state_q  <= ret_q;
					end
				end
				S_DONE: begin
					line_cnt_q <= '0;
					pend_cr_q  <= 1'b0;
					wo_q       <= WO_W'(4);
					eof_mode_q <= 1'b0;
					state_q    <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			c_q <= s_axis_tdata;
		end
		if (state_q == S_FIN) begin
			cnt_q <= cnt_n;
		end
		cp_addr_s1 <= {1'b0, wo_q} + FA_W'(cp_idx_q) + FA_W'(4);
		em_idx_s1  <= em_idx_q;
		em_inb_s1  <= em_inb;
	end

	tlrb_ram #(
		.DEPTH(LINE_DEPTH),
		.AW   (LA_W),
		.DW   (8)
	) u_line_ram (
		.clk  (clk),
		.we   (line_we),
		.waddr(line_cnt_q),
		.wdata(line_wdata),
		.raddr(cp_idx_q),
		.rdata(line_rd)
	);

	tlrb_ram #(
		.DEPTH(BLOCK_BYTES),
		.AW   (BA_W),
		.DW   (8)
	) u_block_ram (
		.clk  (clk),
		.we   (bw_we),
		.waddr(bw_addr[BA_W-1:0]),
		.wdata(bw_data),
		.raddr(em_idx_q[BA_W-1:0]),
		.rdata(blk_rd)
	);

	always_comb begin
		cap.valid     = em_v_s1;
		cap.data      = em_inb_s1 ? blk_rd : 8'h00;
		cap.piece_end = s1_piece_end;
		cap.eob       = em_idx_s1 == EI_W'(EMIT_SPAN - 1);
		cap.eof       = eof_mode_q;
		cap.last      = emit_last_q;
	end

	tlrb_drain u_drain (
		.clk          (clk),
		.arst_n       (arst_n),
		.cap          (cap),
		.full         (full),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	a_line_below_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> ({1'b0, line_cnt_q} < 9'(LINE_LIMIT - 1)))
		else $error("line count at limit while idle");

	a_offset_in_block: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> ({1'b0, wo_q} < FA_W'(BLOCK_BYTES - 1)))
		else $error("write offset past block end");

	a_last_on_block_end: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser[0])
		else $error("last transfer not at block end");

	a_no_capture_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(em_v_s1 && full) |-> 1'b0)
		else $error("byte captured into a finished piece");

endmodule
